// File: sv/sps_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sps_pkg: shared types and constants for the segmented prime sieve
// Holds the controller state type, command and status structs.
// ============================================================================
package sps_pkg;

   localparam int WINDOW_MAX_DEF  = 4096;
   localparam int PRIME_MAX_DEF   = 4096;
   localparam int NUMBER_BITS_DEF = 33;
   localparam int SIZE_W  = 13;
   localparam int LIMIT_W = 32;
   localparam int OUT_W   = 33;
   localparam int SIZE_MIN = 5;

   localparam logic [0:0] CSR_WINDOW_SIZE = 1'b0;
   localparam logic [0:0] CSR_UPPER_LIMIT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR_BMP,
      ST_LOAD_PRIME,
      ST_WAIT_PRIME,
      ST_STRIKE_OLD,
      ST_STORE_OLD,
      ST_READ_BMP,
      ST_WAIT_BMP,
      ST_STRIKE_NEW,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_all;      // restart request
      logic enter_start;    // latch window size, reset sweep index
      logic clear_step;     // write one bitmap entry to prime
      logic load_prime;     // issue read of stored prime k
      logic latch_prime;    // capture read data into strike unit
      logic strike_step;    // one strike of the active prime
      logic store_old;      // write back next multiple, advance k
      logic read_bmp;       // issue bitmap read for current offset
      logic start_new;      // set up strike of new prime
      logic finish;         // store prime, advance offset, build response
      logic resp_halt;      // respond with table_full
      logic resp_done;      // respond with done_res
      logic resp_zero;      // respond all zero
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic halted;
      logic entered;
      logic done_now;
      logic clear_last;
      logic more_primes;
      logic strike_busy;
      logic bmp_prime;
   } sts_type;

endpackage

// File: sv/sps_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// sps_ctrl: sieve sequencer
// Steps through window entry, bitmap read, striking and response hand-off.
// ============================================================================
module sps_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_restart,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output sps_pkg::cmd_type cmd,
   input  sps_pkg::sts_type sts
);
   import sps_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      go;

   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign go        = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               if (req_restart || sts.halted || (!sts.entered && sts.done_now))
                  state_in = ST_RESPOND;
               else if (!sts.entered)
                  state_in = ST_CLEAR_BMP;
               else
                  state_in = ST_READ_BMP;
            end
         end
         ST_CLEAR_BMP:  if (sts.clear_last) state_in = ST_LOAD_PRIME;
         ST_LOAD_PRIME: state_in = sts.more_primes ? ST_WAIT_PRIME : ST_READ_BMP;
         ST_WAIT_PRIME: state_in = ST_STRIKE_OLD;
         ST_STRIKE_OLD: if (!sts.strike_busy) state_in = ST_STORE_OLD;
         ST_STORE_OLD:  state_in = ST_LOAD_PRIME;
         ST_READ_BMP:   state_in = ST_WAIT_BMP;
         ST_WAIT_BMP:   state_in = sts.bmp_prime ? ST_STRIKE_NEW : ST_FINISH;
         ST_STRIKE_NEW: if (!sts.strike_busy) state_in = ST_FINISH;
         ST_FINISH:     state_in = ST_RESPOND;
         ST_RESPOND:    state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               if (req_restart)        cmd.clear_all = 1'b1;
               else if (sts.halted)    cmd.resp_halt = 1'b1;
               else if (!sts.entered && sts.done_now) cmd.resp_done = 1'b1;
               else if (!sts.entered)  cmd.enter_start = 1'b1;
            end
         end
         ST_CLEAR_BMP:  cmd.clear_step  = 1'b1;
         ST_LOAD_PRIME: cmd.load_prime  = 1'b1;
         ST_WAIT_PRIME: cmd.latch_prime = 1'b1;
         ST_STRIKE_OLD: cmd.strike_step = 1'b1;
         ST_STORE_OLD:  cmd.store_old   = 1'b1;
         ST_READ_BMP:   cmd.read_bmp    = 1'b1;
         ST_WAIT_BMP:   cmd.start_new   = sts.bmp_prime;
         ST_STRIKE_NEW: cmd.strike_step = 1'b1;
         ST_FINISH:     cmd.finish      = 1'b1;
         ST_RESPOND:    cmd.resp_zero   = 1'b0;
         default:       cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == ST_RESPOND)    rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/sps_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// sps_datapath: sieve storage and arithmetic
// Bitmap memory, prime tables, window counters and the strike unit.
// ============================================================================
module sps_datapath #(
   parameter int WINDOW_MAX  = sps_pkg::WINDOW_MAX_DEF,
   parameter int PRIME_MAX   = sps_pkg::PRIME_MAX_DEF,
   parameter int NUMBER_BITS = sps_pkg::NUMBER_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [0:0]                   csr_index,
   input  logic [sps_pkg::LIMIT_W-1:0]  csr_data,
   input  sps_pkg::cmd_type             cmd,
   output sps_pkg::sts_type             sts,
   output logic [sps_pkg::OUT_W-1:0]    rsp_candidate,
   output logic                         rsp_found_prime,
   output logic [sps_pkg::OUT_W-1:0]    rsp_next_multiple,
   output logic                         rsp_window_last,
   output logic                         rsp_done_res,
   output logic                         rsp_table_full
);
   import sps_pkg::*;

   localparam int WB = $clog2(WINDOW_MAX);
   localparam int WC = $clog2(WINDOW_MAX + 1);
   localparam int PB = $clog2(PRIME_MAX);
   localparam int PC = $clog2(PRIME_MAX + 1);
   localparam int NB = NUMBER_BITS;
   localparam logic [NB-1:0] NUM_MAX = '1;

   // Configuration
   logic [SIZE_W-1:0]  window_size_ff;
   logic [LIMIT_W-1:0] upper_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= SIZE_W'(4096);
         upper_limit_ff <= LIMIT_W'(65536);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE: window_size_ff <= csr_data[SIZE_W-1:0];
            CSR_UPPER_LIMIT: upper_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Saturated window size
   logic [WC-1:0] size_sat;
   always_comb begin
      if ({1'b0, window_size_ff} < (SIZE_W+1)'(SIZE_MIN))
         size_sat = WC'(SIZE_MIN);
      else if ({1'b0, window_size_ff} > (SIZE_W+1)'(WINDOW_MAX))
         size_sat = WC'(WINDOW_MAX);
      else
         size_sat = WC'(window_size_ff);
   end

   // Control state
   logic [PC-1:0] prime_count_ff;
   logic [NB-1:0] window_base_ff;
   logic [WC-1:0] window_offset_ff;
   logic [WC-1:0] cur_size_ff;
   logic          halted_ff, entered_ff, finished_ff;
   logic [PC-1:0] k_ff;
   logic [WC-1:0] sweep_ff;

   // Memories
   logic          bitmap_mem [WINDOW_MAX];
   logic [NB-1:0] pval_mem   [PRIME_MAX];
   logic [NB-1:0] pnext_mem  [PRIME_MAX];
   logic          bmp_rd_ff;
   logic [NB-1:0] pval_rd_ff, pnext_rd_ff;

   // Strike unit
   logic [NB-1:0] from_ff, step_ff;
   logic [NB:0]   win_end;
   logic          strike_busy;
   logic [NB-1:0] sidx;

   assign win_end     = {1'b0, window_base_ff} + (NB+1)'(cur_size_ff);
   assign strike_busy = (step_ff != '0) && ({1'b0, from_ff} < win_end);
   assign sidx        = from_ff - window_base_ff;

   // Candidate and doubling
   logic [WC-1:0] offs_clip;
   logic [NB-1:0] cand;
   logic [NB:0]   dbl;
   assign offs_clip = (window_offset_ff >= cur_size_ff) ? cur_size_ff - WC'(1)
                                                       : window_offset_ff;
   assign cand = window_base_ff + NB'(offs_clip);
   assign dbl  = {cand, 1'b0};

   // Bitmap: one write port, one registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_step)
         bitmap_mem[sweep_ff[WB-1:0]] <= 1'b1;
      else if (cmd.strike_step && strike_busy && from_ff >= window_base_ff
               && {1'b0, sidx} < (NB+1)'(WINDOW_MAX))
         bitmap_mem[sidx[WB-1:0]] <= 1'b0;
      if (cmd.read_bmp)
         bmp_rd_ff <= bitmap_mem[offs_clip[WB-1:0]];
   end

   // Prime tables
   always_ff @(posedge clock) begin
      if (cmd.store_old)
         pnext_mem[k_ff[PB-1:0]] <= from_ff;
      else if (cmd.finish && bmp_rd_ff && prime_count_ff < PC'(PRIME_MAX)) begin
         pnext_mem[prime_count_ff[PB-1:0]] <= from_ff;
      end
      if (cmd.finish && bmp_rd_ff && prime_count_ff < PC'(PRIME_MAX))
         pval_mem[prime_count_ff[PB-1:0]] <= cand;
      if (cmd.load_prime) begin
         pval_rd_ff  <= pval_mem[k_ff[PB-1:0]];
         pnext_rd_ff <= pnext_mem[k_ff[PB-1:0]];
      end
   end

   // Strike register: one add per cycle, saturating
   always_ff @(posedge clock) begin
      if (cmd.latch_prime) begin
         from_ff <= pnext_rd_ff;
         step_ff <= pval_rd_ff;
      end else if (cmd.start_new) begin
         from_ff <= dbl[NB] ? NUM_MAX : dbl[NB-1:0];
         step_ff <= cand;
      end else if (cmd.strike_step && strike_busy) begin
         if (from_ff > NUM_MAX - step_ff) begin
            from_ff <= NUM_MAX;
            step_ff <= '0;
         end else begin
            from_ff <= from_ff + step_ff;
         end
      end
   end

   // Window bookkeeping
   logic [WC-1:0] offs_next;
   logic          last_now;
   logic [NB:0]   base_sum;
   logic          fin_next;
   logic [NB-1:0] base_next;
   assign offs_next = offs_clip + WC'(1);
   assign last_now  = offs_next >= cur_size_ff;
   assign base_sum  = {1'b0, window_base_ff} + (NB+1)'(cur_size_ff);
   assign fin_next  = finished_ff || base_sum[NB];
   assign base_next = base_sum[NB] ? window_base_ff : base_sum[NB-1:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         prime_count_ff   <= '0;
         window_base_ff   <= '0;
         window_offset_ff <= WC'(2);
         halted_ff        <= 1'b0;
         entered_ff       <= 1'b0;
         finished_ff      <= 1'b0;
         k_ff             <= '0;
         sweep_ff         <= '0;
         cur_size_ff      <= size_sat;
      end else begin
         if (cmd.enter_start) begin
            cur_size_ff <= size_sat;
            sweep_ff    <= '0;
            k_ff        <= '0;
            entered_ff  <= 1'b1;
         end
         if (cmd.clear_step) sweep_ff <= sweep_ff + WC'(1);
         if (cmd.store_old)  k_ff <= k_ff + PC'(1);
         if (cmd.finish) begin
            if (bmp_rd_ff) begin
               if (prime_count_ff < PC'(PRIME_MAX))
                  prime_count_ff <= prime_count_ff + PC'(1);
               else
                  halted_ff <= 1'b1;
            end
            if (last_now) begin
               window_offset_ff <= '0;
               entered_ff       <= 1'b0;
               finished_ff      <= fin_next;
               window_base_ff   <= base_next;
            end else begin
               window_offset_ff <= offs_next;
            end
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.clear_all || cmd.resp_halt || cmd.resp_done || cmd.resp_zero) begin
         rsp_candidate     <= '0;
         rsp_found_prime   <= 1'b0;
         rsp_next_multiple <= '0;
         rsp_window_last   <= 1'b0;
         rsp_done_res      <= cmd.resp_done;
         rsp_table_full    <= cmd.resp_halt;
      end else if (cmd.finish) begin
         rsp_candidate     <= OUT_W'(cand);
         rsp_found_prime   <= bmp_rd_ff;
         rsp_next_multiple <= bmp_rd_ff ? OUT_W'(from_ff) : '0;
         rsp_window_last   <= last_now;
         rsp_done_res      <= last_now &&
                              (fin_next || {1'b0, base_next} >= (NB+1)'(upper_limit_ff));
         rsp_table_full    <= bmp_rd_ff && !(prime_count_ff < PC'(PRIME_MAX));
      end
   end

   assign sts.halted      = halted_ff;
   assign sts.entered     = entered_ff;
   assign sts.done_now    = finished_ff || {1'b0, window_base_ff} >= (NB+1)'(upper_limit_ff);
   assign sts.clear_last  = sweep_ff == WC'(WINDOW_MAX - 1);
   assign sts.more_primes = k_ff < prime_count_ff;
   assign sts.strike_busy = strike_busy;
   assign sts.bmp_prime   = bmp_rd_ff;

endmodule

// File: sv/segmented_prime_sieve.sv
`timescale 1ns / 1ps
// A request inside a window answers after its bitmap read, and after striking the
// candidate's multiples when it is prime; entering a window first clears the whole
// bitmap, then loads and restrikes every stored prime.
// Restart, halted and finished requests go straight to the response. One request is in
// flight at a time; the next is taken the cycle after its response is accepted.
// Reset is synchronous active high; memories are not cleared by reset.
// ============================================================================
// segmented_prime_sieve: segmented Eratosthenes sieve, one candidate a request
// Controller sequences the datapath's bitmap, prime tables and strike unit.
// ============================================================================
module segmented_prime_sieve #(
   parameter int WINDOW_MAX  = sps_pkg::WINDOW_MAX_DEF,
   parameter int PRIME_MAX   = sps_pkg::PRIME_MAX_DEF,
   parameter int NUMBER_BITS = sps_pkg::NUMBER_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [0:0]                  csr_index,
   input  logic [sps_pkg::LIMIT_W-1:0] csr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sps_pkg::OUT_W-1:0]   rsp_candidate,
   output logic                        rsp_found_prime,
   output logic [sps_pkg::OUT_W-1:0]   rsp_next_multiple,
   output logic                        rsp_window_last,
   output logic                        rsp_done_res,
   output logic                        rsp_table_full
);
   import sps_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sps_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_restart,
      .rsp_ready, .rsp_valid, .cmd, .sts
   );

   sps_datapath #(
      .WINDOW_MAX(WINDOW_MAX), .PRIME_MAX(PRIME_MAX), .NUMBER_BITS(NUMBER_BITS)
   ) u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .cmd, .sts,
      .rsp_candidate, .rsp_found_prime, .rsp_next_multiple, .rsp_window_last,
      .rsp_done_res, .rsp_table_full
   );

endmodule

// File: sv/sps_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// sps_checker: port-level checks for the segmented prime sieve
// Watches the request and response channels of the top level.
// ============================================================================
module sps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_restart,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [32:0] rsp_candidate,
   input logic        rsp_found_prime,
   input logic [32:0] rsp_next_multiple,
   input logic        rsp_done_res,
   input logic        rsp_table_full
);
   // No new request while a response waits
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with response pending");

   // Restart answers all zero
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_restart) |=> ##1
      (rsp_valid && rsp_candidate == '0 && !rsp_found_prime && !rsp_done_res
       && !rsp_table_full))
      else $error("restart response not zero");

   // A prime always lies below its next multiple
   a_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found_prime) |-> rsp_next_multiple > rsp_candidate)
      else $error("next multiple not past prime");

   // Stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_candidate)))
      else $error("response dropped while stalled");
endmodule

bind segmented_prime_sieve sps_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .req_restart, .rsp_valid, .rsp_ready,
   .rsp_candidate, .rsp_found_prime, .rsp_next_multiple, .rsp_done_res, .rsp_table_full
);

// File: bench/tb_segmented_prime_sieve.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_segmented_prime_sieve: self-checking bench for the segmented prime sieve
// Drives restart/advance requests in random bursts over several window sizes
// and limits, predicts every response with an independent sieve model held in
// a scoreboard, and checks each response field by field.
// ============================================================================
module tb_segmented_prime_sieve;
   import sps_pkg::*;

   localparam int          TABLE_DEPTH = 4096;
   localparam int          BMP_DEPTH   = 4096;
   localparam longint unsigned NUM_TOP = 64'h1_FFFF_FFFF;
   localparam int          QUIET_LIMIT = 200000;

   typedef struct packed {
      logic [OUT_W-1:0] candidate;
      logic             found_prime;
      logic [OUT_W-1:0] next_multiple;
      logic             window_last;
      logic             done_res;
      logic             table_full;
   } sieve_rsp_t;

   // Scoreboard: sieve predictor plus the queue of expected responses
   class sieve_scoreboard;
      bit [SIZE_W-1:0]  size_reg;
      bit [LIMIT_W-1:0] limit_reg;
      bit               bitmap [BMP_DEPTH];
      longint unsigned  prime_val [TABLE_DEPTH];
      longint unsigned  prime_nxt [TABLE_DEPTH];
      int unsigned      stored;
      int unsigned      offset;
      int unsigned      span;
      longint unsigned  base;
      bit               halted, entered, finished;
      sieve_rsp_t       expected_q [$];
      int               errors;

      function new();
         size_reg  = 13'd4096;
         limit_reg = 32'd65536;
         errors    = 0;
         restart_sieve();
      endfunction

      function void write_reg(logic [0:0] idx, logic [LIMIT_W-1:0] value);
         if (idx == CSR_WINDOW_SIZE) size_reg = value[SIZE_W-1:0];
         else limit_reg = value;
      endfunction

      function int unsigned clamped_size();
         int unsigned s;
         s = size_reg;
         if (s < SIZE_MIN) s = SIZE_MIN;
         if (s > BMP_DEPTH) s = BMP_DEPTH;
         return s;
      endfunction

      function void restart_sieve();
         stored   = 0;
         base     = 0;
         offset   = 2;
         halted   = 0;
         entered  = 0;
         finished = 0;
         span     = clamped_size();
      endfunction

      // Strike multiples inside the current window; return first one past it
      function longint unsigned strike_run(longint unsigned from, longint unsigned step);
         longint unsigned stop;
         stop = base + span;
         if (step == 0) return from;
         while (from < stop) begin
            if (from >= base && (from - base) < BMP_DEPTH) bitmap[from - base] = 0;
            if (from > NUM_TOP - step) return NUM_TOP;
            from += step;
         end
         return from;
      endfunction

      function bit sieve_over();
         return finished || base >= limit_reg;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Predict the response of one accepted request
      function void note_request(bit restart);
         sieve_rsp_t r;
         longint unsigned cand, from;
         r = '0;
         if (restart) begin
            restart_sieve();
         end else if (halted) begin
            r.table_full = 1;
         end else if (!entered && sieve_over()) begin
            r.done_res = 1;
         end else begin
            if (!entered) begin
               span = clamped_size();
               foreach (bitmap[i]) bitmap[i] = 1;
               for (int k = 0; k < stored; k++)
                  prime_nxt[k] = strike_run(prime_nxt[k], prime_val[k]);
               entered = 1;
            end
            if (offset >= span) offset = span - 1;
            cand = base + offset;
            r.candidate = cand[OUT_W-1:0];
            if (bitmap[offset]) begin
               from = (cand > NUM_TOP - cand) ? NUM_TOP : cand + cand;
               from = strike_run(from, cand);
               r.found_prime = 1;
               r.next_multiple = from[OUT_W-1:0];
               if (stored < TABLE_DEPTH) begin
                  prime_val[stored] = cand;
                  prime_nxt[stored] = from;
                  stored++;
               end else begin
                  halted = 1;
                  r.table_full = 1;
               end
            end
            offset++;
            if (offset >= span) begin
               r.window_last = 1;
               offset  = 0;
               entered = 0;
               if (base > NUM_TOP - span) finished = 1;
               else base += span;
               r.done_res = sieve_over();
            end
         end
         expected_q.push_back(r);
      endfunction

      function void field_check(string name, longint unsigned exp_v, longint unsigned act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Compare one response with the oldest expectation
      function void check_response(sieve_rsp_t act);
         sieve_rsp_t e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, act);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         field_check("candidate", e.candidate, act.candidate);
         field_check("found_prime", e.found_prime, act.found_prime);
         field_check("next_multiple", e.next_multiple, act.next_multiple);
         field_check("window_last", e.window_last, act.window_last);
         field_check("done_res", e.done_res, act.done_res);
         field_check("table_full", e.table_full, act.table_full);
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_write = 0;
   logic [0:0]         csr_index = CSR_WINDOW_SIZE;
   logic [LIMIT_W-1:0] csr_data = '0;
   logic               req_valid = 0;
   logic               req_ready;
   logic               req_restart = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [OUT_W-1:0]   rsp_candidate;
   logic               rsp_found_prime;
   logic [OUT_W-1:0]   rsp_next_multiple;
   logic               rsp_window_last;
   logic               rsp_done_res;
   logic               rsp_table_full;

   sieve_scoreboard sb = new();
   bit              hold_off = 0;
   int              quiet_cycles = 0;

   segmented_prime_sieve uut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_candidate(rsp_candidate), .rsp_found_prime(rsp_found_prime),
      .rsp_next_multiple(rsp_next_multiple), .rsp_window_last(rsp_window_last),
      .rsp_done_res(rsp_done_res), .rsp_table_full(rsp_table_full)
   );

   always begin
      clock = 1;
      #4;
      clock = 0;
      #4;
   end

   // Check accepted responses
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response({rsp_candidate, rsp_found_prime, rsp_next_multiple,
                            rsp_window_last, rsp_done_res, rsp_table_full});
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL segmented_prime_sieve");
         $finish;
      end
   end

   // Receiver: stall pattern changes every stretch; hold off on request
   initial begin
      int mode, left, held;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            held = 400;
            rsp_ready <= 0;
            repeat (held) @(negedge clock);
            hold_off = 0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(16, 96);
         end
         left--;
         case (mode)
            0, 1: begin
               rsp_ready <= 1;
            end
            2: begin
               rsp_ready <= $urandom_range(0, 1);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // Offer one request and hold it until accepted; returns at a falling edge
   task automatic send_request(bit restart);
      req_valid   <= 1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      sb.note_request(restart);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [LIMIT_W-1:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data  <= value;
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_write <= 0;
      @(negedge clock);
   endtask

   // Bursts of mostly advance requests with rare restarts
   task automatic run_burst_phase(int count, int restart_odds, int max_gap,
                                  bit with_hold, bit with_pause);
      int burst_left, gap;
      bit restart;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 3) hold_off = 1;
         if (with_pause && i == count / 2) begin
            req_valid <= 0;
            do @(negedge clock); while (sb.pending() != 0);
         end else if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
               req_valid <= 0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 24);
         end
         restart = (restart_odds > 0) && ($urandom_range(1, restart_odds) == 1);
         send_request(restart);
         if (burst_left > 0) burst_left--;
      end
      req_valid <= 0;
      wait_drained();
   endtask

   initial begin
      bit [SIZE_W-1:0]  sizes  [5] = '{13'd5, 13'd4096, 13'd37, 13'd8191, 13'd300};
      bit [LIMIT_W-1:0] limits [5] = '{32'd60, 32'd65536, 32'd5000, 32'hFFFF_FFFF, 32'd2000};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: size below minimum, smallest limit, finish and restart
      write_csr(CSR_WINDOW_SIZE, 32'd0);
      write_csr(CSR_UPPER_LIMIT, 32'd5);
      send_request(1);
      repeat (6) send_request(0);
      send_request(1);
      send_request(1);
      repeat (4) send_request(0);
      req_valid <= 0;
      wait_drained();

      // Directed: size above maximum, largest limit
      write_csr(CSR_WINDOW_SIZE, 32'd8191);
      write_csr(CSR_UPPER_LIMIT, 32'hFFFF_FFFF);
      send_request(1);
      repeat (10) send_request(0);
      req_valid <= 0;
      wait_drained();

      // Random phases over several settings
      for (int p = 0; p < 5; p++) begin
         write_csr(CSR_WINDOW_SIZE, sizes[p]);
         write_csr(CSR_UPPER_LIMIT, limits[p]);
         send_request(1);
         run_burst_phase(180, 80, 6, p == 1, p == 2);
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("PASS segmented_prime_sieve");
      else $display("FAIL segmented_prime_sieve");
      $finish;
   end

endmodule
